/* src/grid_box_mean_3x3_assert.svh */
// Assertion macros shared by the grid box mean modules.
`ifndef GRID_BOX_MEAN_3X3_ASSERT_SVH
`define GRID_BOX_MEAN_3X3_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GBM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("grid box mean: assertion failed");
`define GBM_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("grid box mean: assertion failed");
`else
`define GBM_ASSERT(lbl, prop)
`define GBM_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* src/gbm_pkg.sv */
// Types, constants and register codes of the 3x3 grid box mean.
`timescale 1ns / 1ps
package gbm_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int CSUM_W        = SAMPLE_BITS + 2;
    localparam int SUM_W         = SAMPLE_BITS + 4;
    localparam int DIV_K         = SUM_W + 4;
    localparam int PROD_W        = SUM_W + DIV_K;
    localparam int LANE_LAT      = 3;

    localparam logic [DIV_K-1:0] RECIP4 = DIV_K'((64'd1 << DIV_K) / 4);
    localparam logic [DIV_K-1:0] RECIP6 = DIV_K'(((64'd1 << DIV_K) + 64'd5) / 6);
    localparam logic [DIV_K-1:0] RECIP9 = DIV_K'(((64'd1 << DIV_K) + 64'd8) / 9);

    localparam int COLS_W        = 6;
    localparam int ROWS_W        = 11;
    localparam int CFG_W         = 11;
    localparam int CFG_IDX_W     = 2;
    localparam int MAX_COLS_DEF  = 32;
    localparam int MAX_ROWS_DEF  = 1024;
    localparam int GRID_COLS_RST = 32;
    localparam int GRID_ROWS_RST = 32;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(1);

    typedef logic [SAMPLE_BITS-1:0] t_smp;

    typedef struct packed {
        t_smp sample_a;
        t_smp sample_b;
    } t_in;

    typedef struct packed {
        t_smp mean_a;
        t_smp mean_b;
        logic row_end;
        logic frame_end;
        logic last_in_run;
    } t_out;

    typedef struct packed {
        t_smp b;
        t_smp a;
    } t_pix;

    // rows of one window column: top, middle, bottom
    typedef t_pix [2:0] t_col;

    typedef enum logic [1:0] {
        DIV4,
        DIV6,
        DIV9
    } t_div;

    typedef struct packed {
        logic top;
        logic bot;
        logic left;
        logic right;
        t_div div;
    } t_win_ctl;

    typedef struct packed {
        logic row_end;
        logic frame_end;
        logic last;
    } t_flags;

    typedef struct packed {
        t_col [2:0] win;
        t_win_ctl   ctl;
        t_flags     flags;
    } t_job;

    // one channel of a window, [column][row]
    typedef t_smp [2:0][2:0] t_lane_win;

endpackage

/* src/gbm_lane.sv */
// One channel lane: masked window sum and division by 4, 6 or 9.
`timescale 1ns / 1ps
module gbm_lane import gbm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_adv,
    input  t_lane_win i_win,
    input  t_win_ctl  i_ctl,
    output t_smp      o_mean
);

    logic [CSUM_W-1:0] n_csum [3];
    logic [CSUM_W-1:0] r_csum [3];
    t_div              r_div1;
    t_div              r_div2;
    logic [SUM_W-1:0]  r_sum;
    logic [PROD_W-1:0] r_prod;
    logic [DIV_K-1:0]  recip;

    always_comb begin
        for (int x = 0; x < 3; x++) begin
            n_csum[x] = '0;
            for (int y = 0; y < 3; y++) begin
                if ((y != 0 || i_ctl.top) && (y != 2 || i_ctl.bot)) begin
                    n_csum[x] = n_csum[x] + CSUM_W'(i_win[x][y]);
                end
            end
            if ((x == 0 && !i_ctl.left) || (x == 2 && !i_ctl.right)) begin
                n_csum[x] = '0;
            end
        end
    end

    always_comb begin
        case (r_div2)
            DIV4:    recip = RECIP4;
            DIV6:    recip = RECIP6;
            DIV9:    recip = RECIP9;
            default: recip = RECIP9;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int x = 0; x < 3; x++) begin
                r_csum[x] <= n_csum[x];
            end
            r_div1 <= i_ctl.div;
            r_sum  <= SUM_W'(r_csum[0]) + SUM_W'(r_csum[1]) + SUM_W'(r_csum[2]);
            r_div2 <= r_div1;
            r_prod <= PROD_W'(r_sum) * PROD_W'(recip);
        end
    end

    assign o_mean = r_prod[DIV_K +: SAMPLE_BITS];

endmodule

/* src/gbm_merge.sv */
// Merge stage: joins lane means with flags into the output word register.
`timescale 1ns / 1ps
`include "grid_box_mean_3x3_assert.svh"
module gbm_merge import gbm_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_issue,
    input  t_flags i_flags,
    input  t_smp   i_mean_a,
    input  t_smp   i_mean_b,
    input  logic   i_out_stall,
    output logic   o_adv,
    output logic   o_out_valid,
    output t_out   o_out_data
);

    logic [LANE_LAT-1:0] r_vld;
    t_flags              r_flags [LANE_LAT];
    logic                r_out_valid;
    t_out                r_out_data;

    assign o_adv       = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_vld       <= {r_vld[LANE_LAT-2:0], i_issue};
            r_out_valid <= r_vld[LANE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_flags[0] <= i_flags;
            for (int k = 1; k < LANE_LAT; k++) begin
                r_flags[k] <= r_flags[k-1];
            end
            r_out_data.mean_a      <= i_mean_a;
            r_out_data.mean_b      <= i_mean_b;
            r_out_data.row_end     <= r_flags[LANE_LAT-1].row_end;
            r_out_data.frame_end   <= r_flags[LANE_LAT-1].frame_end;
            r_out_data.last_in_run <= r_flags[LANE_LAT-1].last;
        end
    end

    `GBM_ASSERT(a_out_from_pipe, $rose(o_out_valid) |-> $past(r_vld[LANE_LAT-1]))
    `GBM_ASSERT(a_hold_on_stall, (o_out_valid && i_out_stall) |=> $stable(r_vld))
    `GBM_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_out_valid)

endmodule

/* src/gbm_ctrl.sv */
// Sequencer: row stores, window columns, raster position and window issue.
`timescale 1ns / 1ps
`include "grid_box_mean_3x3_assert.svh"
module gbm_ctrl import gbm_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_adv,
    output logic                 o_issue,
    output t_job                 o_job
);

    localparam int COL_PW   = $clog2(MAX_COLS);
    localparam int ROW_PW   = $clog2(MAX_ROWS);
    localparam int COLS_RST = (MAX_COLS < GRID_COLS_RST) ? MAX_COLS : GRID_COLS_RST;
    localparam int ROWS_RST = (MAX_ROWS < GRID_ROWS_RST) ? MAX_ROWS : GRID_ROWS_RST;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_JOB1,
        S_JOB2,
        S_FPRIME,
        S_FFILL,
        S_FLUSH
    } t_state;

    t_state              r_state;
    logic [COLS_W-1:0]   r_cols;
    logic [ROWS_W-1:0]   r_rows;
    logic [COL_PW-1:0]   r_col;
    logic [ROW_PW-1:0]   r_row;
    logic [COL_PW-1:0]   r_fc;
    logic                r_top;
    logic                r_left;
    logic                r_do2;
    logic                r_dofl;
    t_pix                r_smp;
    t_pix                r_rd_up;
    t_pix                r_rd_mid;
    t_col [2:0]          r_w;

    t_pix                mem_up  [MAX_COLS];
    t_pix                mem_mid [MAX_COLS];

    logic                acc;
    logic                last_col;
    logic                last_row;
    logic                fc_last;
    logic                rd_en;
    logic                wr_en;
    logic [COL_PW-1:0]   rd_addr;
    logic [COLS_W-1:0]   cfg_cols;
    logic [ROWS_W-1:0]   cfg_rows;
    t_col                new_col;
    t_col                rd_col;
    t_job                job;
    logic                issue;

    function automatic t_div div_of(input logic top, input logic bot,
                                    input logic left, input logic right);
        logic tall;
        logic wide;
        tall = top && bot;
        wide = left && right;
        if (tall && wide) begin
            return DIV9;
        end else if (tall || wide) begin
            return DIV6;
        end
        return DIV4;
    endfunction

    assign o_in_stall = (r_state != S_IDLE);
    assign acc        = i_in_valid && (r_state == S_IDLE);
    assign last_col   = (32'(r_col) + 1 == 32'(r_cols));
    assign last_row   = (32'(r_row) + 1 >= 32'(r_rows));
    assign fc_last    = (32'(r_fc) + 1 == 32'(r_cols));
    assign wr_en      = (r_state == S_LOAD);

    assign new_col[0] = r_rd_up;
    assign new_col[1] = r_rd_mid;
    assign new_col[2] = r_smp;
    assign rd_col[0]  = r_rd_up;
    assign rd_col[1]  = r_rd_mid;
    assign rd_col[2]  = '0;

    always_comb begin
        cfg_cols = i_cfg_data[COLS_W-1:0];
        if (cfg_cols < COLS_W'(2)) begin
            cfg_cols = COLS_W'(2);
        end else if (32'(cfg_cols) > MAX_COLS) begin
            cfg_cols = COLS_W'(MAX_COLS);
        end
        cfg_rows = i_cfg_data[ROWS_W-1:0];
        if (cfg_rows < ROWS_W'(2)) begin
            cfg_rows = ROWS_W'(2);
        end else if (32'(cfg_rows) > MAX_ROWS) begin
            cfg_rows = ROWS_W'(MAX_ROWS);
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_col;
        case (r_state)
            S_IDLE: begin
                rd_en = i_in_valid;
            end
            S_FPRIME: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            S_FFILL: begin
                rd_en   = 1'b1;
                rd_addr = COL_PW'(1);
            end
            S_FLUSH: begin
                rd_en   = i_adv && (32'(r_fc) + 2 < 32'(r_cols));
                rd_addr = COL_PW'(32'(r_fc) + 2);
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_up[r_col]  <= r_rd_mid;
            mem_mid[r_col] <= r_smp;
        end
        if (rd_en) begin
            r_rd_up  <= mem_up[rd_addr];
            r_rd_mid <= mem_mid[rd_addr];
        end
    end

    always_comb begin
        job   = '0;
        issue = 1'b0;
        case (r_state)
            S_JOB1: begin
                issue           = 1'b1;
                job.win         = r_w;
                job.ctl.top     = r_top;
                job.ctl.bot     = 1'b1;
                job.ctl.left    = r_left;
                job.ctl.right   = 1'b1;
                job.flags.last  = !r_do2;
            end
            S_JOB2: begin
                issue               = 1'b1;
                job.win[0]          = r_w[1];
                job.win[1]          = r_w[2];
                job.ctl.top         = r_top;
                job.ctl.bot         = 1'b1;
                job.ctl.left        = 1'b1;
                job.ctl.right       = 1'b0;
                job.flags.row_end   = 1'b1;
                job.flags.last      = !r_dofl;
            end
            S_FLUSH: begin
                issue               = 1'b1;
                job.win[0]          = r_w[1];
                job.win[1]          = r_w[2];
                job.win[2]          = rd_col;
                job.ctl.top         = 1'b1;
                job.ctl.bot         = 1'b0;
                job.ctl.left        = (r_fc != '0);
                job.ctl.right       = !fc_last;
                job.flags.row_end   = fc_last;
                job.flags.frame_end = fc_last;
                job.flags.last      = fc_last;
            end
            default: begin
                issue = 1'b0;
            end
        endcase
        job.ctl.div = div_of(job.ctl.top, job.ctl.bot, job.ctl.left, job.ctl.right);
    end

    assign o_issue = issue;
    assign o_job   = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cols  <= COLS_W'(COLS_RST);
            r_rows  <= ROWS_W'(ROWS_RST);
            r_col   <= '0;
            r_row   <= '0;
            r_fc    <= '0;
            r_top   <= 1'b0;
            r_left  <= 1'b0;
            r_do2   <= 1'b0;
            r_dofl  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_smp.a <= i_in_data.sample_a;
                        r_smp.b <= i_in_data.sample_b;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_w[0] <= r_w[1];
                    r_w[1] <= r_w[2];
                    r_w[2] <= new_col;
                    r_top  <= (32'(r_row) >= 2);
                    r_left <= (32'(r_col) >= 2);
                    r_do2  <= last_col;
                    r_dofl <= last_col && last_row;
                    if (last_col) begin
                        r_col <= '0;
                        if (last_row) begin
                            r_row <= '0;
                        end else begin
                            r_row <= r_row + ROW_PW'(1);
                        end
                    end else begin
                        r_col <= r_col + COL_PW'(1);
                    end
                    if (r_row != '0 && r_col != '0) begin
                        r_state <= S_JOB1;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_JOB1: begin
                    if (i_adv) begin
                        r_state <= r_do2 ? S_JOB2 : S_IDLE;
                    end
                end
                S_JOB2: begin
                    if (i_adv) begin
                        r_state <= r_dofl ? S_FPRIME : S_IDLE;
                    end
                end
                S_FPRIME: begin
                    r_state <= S_FFILL;
                end
                S_FFILL: begin
                    r_w[2]  <= rd_col;
                    r_fc    <= '0;
                    r_state <= S_FLUSH;
                end
                S_FLUSH: begin
                    if (i_adv) begin
                        r_w[0] <= r_w[1];
                        r_w[1] <= r_w[2];
                        r_w[2] <= rd_col;
                        r_fc   <= r_fc + COL_PW'(1);
                        if (fc_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_GRID_COLS: begin
                        r_cols <= cfg_cols;
                        r_col  <= '0;
                        r_row  <= '0;
                    end
                    REG_GRID_ROWS: begin
                        r_rows <= cfg_rows;
                        r_col  <= '0;
                        r_row  <= '0;
                    end
                    default: begin
                        r_cols <= r_cols;
                    end
                endcase
            end
        end
    end

    `GBM_ASSERT(a_pos_range, (32'(r_col) < 32'(r_cols)) && (32'(r_row) < 32'(r_rows)))
    `GBM_ASSERT(a_frame_end_last, (o_issue && o_job.flags.frame_end) |-> o_job.flags.last)
    `GBM_ASSERT(a_one_item, (i_in_valid && !o_in_stall) |=> o_in_stall)

endmodule

/* src/grid_box_mean_3x3.sv */
// Top level of the 3x3 clipped box mean over a two-channel sample grid.
`timescale 1ns / 1ps
// Samples enter in raster order, grid_cols per row and grid_rows per frame; every grid
// position leaves in raster order as the truncated mean of its 3x3 neighborhood clipped
// to the grid (corner over 4, edge over 6, interior over 9), one row plus one column
// behind the input, and the last sample of a frame also releases the whole final row.
// The sequencer takes one sample at a time: a sample that yields no result, one result or
// two results passes through the registered row store read and the window column load,
// then issues one window per cycle into the two channel lanes while the output does not
// stall; the last sample of a frame also issues the final row. Results trail their window
// through the lane registers and the output register, and a stall on the output holds the
// whole result path. Writing either register restarts the frame; the row stores need no
// clearing after reset.
module grid_box_mean_3x3 import gbm_pkg::*; #(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic      adv;
    logic      issue;
    t_job      job;
    t_lane_win win_a;
    t_lane_win win_b;
    t_smp      mean_a;
    t_smp      mean_b;

    gbm_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_adv       (adv),
        .o_issue     (issue),
        .o_job       (job)
    );

    always_comb begin
        for (int x = 0; x < 3; x++) begin
            for (int y = 0; y < 3; y++) begin
                win_a[x][y] = job.win[x][y].a;
                win_b[x][y] = job.win[x][y].b;
            end
        end
    end

    gbm_lane u_lane_a (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_win  (win_a),
        .i_ctl  (job.ctl),
        .o_mean (mean_a)
    );

    gbm_lane u_lane_b (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_win  (win_b),
        .i_ctl  (job.ctl),
        .o_mean (mean_b)
    );

    gbm_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_flags     (job.flags),
        .i_mean_a    (mean_a),
        .i_mean_b    (mean_b),
        .i_out_stall (i_out_stall),
        .o_adv       (adv),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
